@@ hw/rtl/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the character bigram model files.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int SYM_BITS   = 8;
  localparam int SYMS       = 1 << SYM_BITS;
  localparam int PAIR_BITS  = 2 * SYM_BITS;
  localparam int COUNT_BITS = 32;
  localparam int RATIO_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SCORE_BITS = FRAC_BITS + 1;
  localparam int SUM_BITS   = 40;
  localparam int WCNT_BITS  = 24;

  // divider sizes: dividend is the widest numerator, divisor the widest denominator
  localparam int DIV_NUM_BITS = COUNT_BITS + RATIO_BITS;
  localparam int DIV_DEN_BITS = RATIO_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS);

  localparam logic [1:0] CMD_LEARN    = 2'd0;
  localparam logic [1:0] CMD_FINALIZE = 2'd1;
  localparam logic [1:0] CMD_SCORE    = 2'd2;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_NORM = 1'b1;

  typedef struct packed {
    logic [1:0]          command;
    logic [SYM_BITS-1:0] symbol;
    logic                last;
  } in_t;

  typedef struct packed {
    logic                  result_kind;
    logic [SCORE_BITS-1:0] score;
  } out_t;

endpackage

@@ hw/rtl/char_bigram_model_train_score_top.sv @@
// ----------------------------------------------------------------------------
// char_bigram_model_train_score_top
// Character bigram model: learns pair counts, normalizes, scores words.
// ----------------------------------------------------------------------------
// After reset the block clears its pair count, row total and score memories,
// walking all 65536 pair addresses, and takes no input meanwhile. A learn or
// score symbol then takes one memory read and one update; one that forms no
// pair needs no update. The last symbol of a scored word also computes the
// mean with the shared one-bit-per-cycle divider, unless the word has no pairs.
// Finalize sweeps all 65536 pairs twice through the same divider: the first
// sweep divides each pair of a row with counts once to find the largest ratio,
// the second divides it twice to scale its score; pairs of empty rows, and all
// pairs when no ratio is above zero, skip the divider in the second sweep. One
// item is in work at a time, and a result held by a stalled receiver delays the next one.
module char_bigram_model_train_score_top
  import cbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LEARN    = 4'd2;
  localparam logic [3:0] S_SCORE    = 4'd3;
  localparam logic [3:0] S_WEND     = 4'd4;
  localparam logic [3:0] S_MEAN_DIV = 4'd5;
  localparam logic [3:0] S_F1_RD    = 4'd6;
  localparam logic [3:0] S_F1_CHK   = 4'd7;
  localparam logic [3:0] S_F1_DIV   = 4'd8;
  localparam logic [3:0] S_F2_RD    = 4'd9;
  localparam logic [3:0] S_F2_CHK   = 4'd10;
  localparam logic [3:0] S_F2_DIV1  = 4'd11;
  localparam logic [3:0] S_F2_DIV2  = 4'd12;
  localparam logic [3:0] S_F2_WR    = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;

  localparam logic [SUM_BITS-1:0]  SUM_MAX   = '1;
  localparam logic [WCNT_BITS-1:0] PAIRS_MAX = '1;

  logic [3:0]              state;
  logic [PAIR_BITS-1:0]    idx;
  logic [PAIR_BITS-1:0]    pair_addr;
  logic [SYM_BITS-1:0]     previous_symbol;
  logic                    have_previous;
  logic [SUM_BITS-1:0]     word_score_sum;
  logic [WCNT_BITS-1:0]    word_pair_count;
  logic                    trained;
  logic                    cur_last;
  logic [DIV_DEN_BITS-1:0] best;
  logic [SCORE_BITS-1:0]   result_score;
  logic                    result_kind;

  // divider registers
  logic [DIV_NUM_BITS-1:0] div_num;
  logic [DIV_DEN_BITS-1:0] div_den;
  logic [DIV_DEN_BITS-1:0] div_rem;
  logic [DIV_DEN_BITS-1:0] div_q;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  // memory ports
  logic                    cnt_we, row_we, scr_we;
  logic [PAIR_BITS-1:0]    cnt_addr, scr_addr;
  logic [SYM_BITS-1:0]     row_addr;
  logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata, row_wdata, row_rdata;
  logic [SCORE_BITS-1:0]   scr_wdata, scr_rdata;

  logic                    accept;
  logic [DIV_DEN_BITS:0]   div_trial, div_diff;
  logic                    div_ge;
  logic                    div_done;
  logic [DIV_DEN_BITS-1:0] div_rem_next, div_q_next;
  logic [SUM_BITS:0]       sum_wide;
  logic [SUM_BITS-1:0]     sum_next;
  logic                    idx_end;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_end  = (idx == {PAIR_BITS{1'b1}});

  // one restoring division step per cycle
  assign div_trial    = {div_rem, div_num[DIV_NUM_BITS-1]};
  assign div_diff     = div_trial - {1'b0, div_den};
  assign div_ge       = (div_trial >= {1'b0, div_den});
  assign div_rem_next = div_ge ? div_diff[DIV_DEN_BITS-1:0] : div_trial[DIV_DEN_BITS-1:0];
  assign div_q_next   = {div_q[DIV_DEN_BITS-2:0], div_ge};
  assign div_done     = (div_cnt == DIV_CNT_BITS'(DIV_NUM_BITS - 1));

  // saturating word sum
  assign sum_wide = {1'b0, word_score_sum} + (SUM_BITS + 1)'(scr_rdata);
  assign sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

  // memory address and write selection
  always_comb begin
    cnt_we    = 1'b0;
    row_we    = 1'b0;
    scr_we    = 1'b0;
    cnt_addr  = idx;
    row_addr  = idx[PAIR_BITS-1:SYM_BITS];
    scr_addr  = idx;
    cnt_wdata = '0;
    row_wdata = '0;
    scr_wdata = result_score;
    case (state)
      S_CLEAR: begin
        cnt_we   = 1'b1;
        row_we   = 1'b1;
        scr_we   = 1'b1;
        row_addr = idx[SYM_BITS-1:0];
        scr_wdata = '0;
      end
      S_IDLE: begin
        cnt_addr = {previous_symbol, in_data.symbol};
        scr_addr = {previous_symbol, in_data.symbol};
        row_addr = previous_symbol;
      end
      S_LEARN: begin
        cnt_we    = 1'b1;
        row_we    = 1'b1;
        cnt_addr  = pair_addr;
        row_addr  = pair_addr[PAIR_BITS-1:SYM_BITS];
        cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
        row_wdata = (row_rdata == '1) ? row_rdata : row_rdata + 1'b1;
      end
      S_F2_WR: begin
        scr_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  cbm_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMS * SYMS)) u_pair_counts (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  cbm_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMS)) u_row_totals (
    .clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wdata), .rdata(row_rdata)
  );

  cbm_ram #(.WIDTH(SCORE_BITS), .DEPTH(SYMS * SYMS)) u_pair_scores (
    .clk(clk), .we(scr_we), .addr(scr_addr), .wdata(scr_wdata), .rdata(scr_rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      idx             <= '0;
      previous_symbol <= '0;
      have_previous   <= 1'b0;
      word_score_sum  <= '0;
      word_pair_count <= '0;
      trained         <= 1'b0;
      best            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_F1_DIV || state == S_F2_DIV1 || state == S_F2_DIV2 ||
          state == S_MEAN_DIV) begin
        div_rem <= div_rem_next;
        div_q   <= div_q_next;
        div_num <= div_num << 1;
        div_cnt <= div_cnt + 1'b1;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx_end) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pair_addr <= {previous_symbol, in_data.symbol};
            cur_last  <= in_data.last;
            case (in_data.command)
              CMD_LEARN: begin
                if (!trained) begin
                  previous_symbol <= in_data.symbol;
                  have_previous   <= !in_data.last;
                  if (have_previous) begin
                    state <= S_LEARN;
                  end
                end
              end
              CMD_FINALIZE: begin
                idx   <= '0;
                best  <= '0;
                state <= S_F1_RD;
              end
              CMD_SCORE: begin
                previous_symbol <= in_data.symbol;
                have_previous   <= !in_data.last;
                if (have_previous && word_pair_count != PAIRS_MAX) begin
                  state <= S_SCORE;
                end else if (in_data.last) begin
                  state <= S_WEND;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LEARN: begin
          state <= S_IDLE;
        end
        S_SCORE: begin
          word_score_sum  <= sum_next;
          word_pair_count <= word_pair_count + 1'b1;
          state           <= cur_last ? S_WEND : S_IDLE;
        end
        S_WEND: begin
          result_kind <= KIND_WORD;
          if (word_pair_count == '0) begin
            result_score <= '0;
            state        <= S_OUT;
          end else begin
            div_num <= DIV_NUM_BITS'(word_score_sum);
            div_den <= DIV_DEN_BITS'(word_pair_count);
            div_rem <= '0;
            div_q   <= '0;
            div_cnt <= '0;
            state   <= S_MEAN_DIV;
          end
          word_score_sum  <= '0;
          word_pair_count <= '0;
        end
        S_MEAN_DIV: begin
          if (div_done) begin
            result_score <= div_q_next[SCORE_BITS-1:0];
            state        <= S_OUT;
          end
        end
        // first sweep: largest ratio
        S_F1_RD: begin
          state <= S_F1_CHK;
        end
        S_F1_CHK: begin
          if (row_rdata == '0) begin
            idx   <= idx + 1'b1;
            state <= idx_end ? S_F2_RD : S_F1_RD;
          end else begin
            div_num <= {cnt_rdata, RATIO_BITS'(0)};
            div_den <= DIV_DEN_BITS'(row_rdata);
            div_rem <= '0;
            div_q   <= '0;
            div_cnt <= '0;
            state   <= S_F1_DIV;
          end
        end
        S_F1_DIV: begin
          if (div_done) begin
            if (div_q_next > best) begin
              best <= div_q_next;
            end
            idx   <= idx + 1'b1;
            state <= idx_end ? S_F2_RD : S_F1_RD;
          end
        end
        // second sweep: scaled scores
        S_F2_RD: begin
          state <= S_F2_CHK;
        end
        S_F2_CHK: begin
          if (row_rdata == '0 || best == '0) begin
            result_score <= '0;
            state        <= S_F2_WR;
          end else begin
            div_num <= {cnt_rdata, RATIO_BITS'(0)};
            div_den <= DIV_DEN_BITS'(row_rdata);
            div_rem <= '0;
            div_q   <= '0;
            div_cnt <= '0;
            state   <= S_F2_DIV1;
          end
        end
        S_F2_DIV1: begin
          if (div_done) begin
            div_num <= DIV_NUM_BITS'({div_q_next, FRAC_BITS'(0)});
            div_den <= best;
            div_rem <= '0;
            div_q   <= '0;
            div_cnt <= '0;
            state   <= S_F2_DIV2;
          end
        end
        S_F2_DIV2: begin
          if (div_done) begin
            result_score <= div_q_next[SCORE_BITS-1:0];
            state        <= S_F2_WR;
          end
        end
        S_F2_WR: begin
          idx <= idx + 1'b1;
          if (idx_end) begin
            trained         <= 1'b1;
            have_previous   <= 1'b0;
            word_score_sum  <= '0;
            word_pair_count <= '0;
            result_kind     <= KIND_NORM;
            result_score    <= '0;
            state           <= S_OUT;
          end else begin
            state <= S_F2_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.result_kind <= result_kind;
            out_data.score       <= result_score;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // remainder stays below the divisor while dividing
  assert property (@(posedge clk) disable iff (rst)
    (state == S_F1_DIV || state == S_F2_DIV1 || state == S_F2_DIV2 ||
     state == S_MEAN_DIV) |-> (div_rem < div_den))
    else $error("divider remainder not below divisor");

  // a new result only comes from the output state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

  // learning writes never happen once trained
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LEARN) |-> !trained)
    else $error("learn update after finalize");

  // training completes only by issuing the finish result
  assert property (@(posedge clk) disable iff (rst)
    $rose(trained) |-> (state == S_OUT && result_kind == KIND_NORM))
    else $error("finalize ended without finish result");

endmodule

@@ hw/rtl/cbm_ram.sv @@
// ----------------------------------------------------------------------------
// cbm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write into the array; read data returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ dv/char_bigram_model_train_score_top_test.sv @@
// ----------------------------------------------------------------------------
// char_bigram_model_train_score_top_test
// Self-checking bench for the character bigram model. Directed rows before
// training, random learn lines, directed rows around finalize and random
// scored words follow in turn. Each result is compared with a behavioral model
// of the counts, normalized score table and word mean, or a directed row's value.
// ----------------------------------------------------------------------------
module char_bigram_model_train_score_top_test;
  import cbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]         CMD_NONE   = 2'd3;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX = '1;
  localparam logic [WCNT_BITS-1:0]  WCNT_MAX = '1;

  typedef enum int {
    IDLE_SEND_HEAVY_RECV_HEAVIER,
    IDLE_SEND_HEAVIER_RECV_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct {
    in_t  item;
    bit   known;
    out_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  char_bigram_model_train_score_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [COUNT_BITS-1:0] m_pair_count [int];
  logic [COUNT_BITS-1:0] m_row_total [SYMS];
  logic [SCORE_BITS-1:0] m_pair_score [int];
  logic [SYM_BITS-1:0]   m_prev;
  bit                    m_have_prev;
  logic [SUM_BITS-1:0]   m_word_sum;
  logic [WCNT_BITS-1:0]  m_word_pairs;
  bit                    m_trained;

  out_t       score_q [$];
  idle_mode_e idle_mode = IDLE_SEND_HEAVY_RECV_HEAVIER;
  int         errors = 0;
  int         n_items = 0;
  int         n_results = 0;
  int         n_finalize = 0;

  // floor(num * 2^bits / den)
  function automatic logic [95:0] scaled_div(logic [63:0] num, logic [63:0] den, int bits);
    logic [95:0] wide;
    wide = 96'(num) << bits;
    return wide / 96'(den);
  endfunction

  function automatic int idle_pct(bit sender);
    case (idle_mode)
      IDLE_SEND_HEAVY_RECV_HEAVIER: return sender ? 35 : 61;
      IDLE_SEND_HEAVIER_RECV_HEAVY: return sender ? 61 : 35;
      default: return 0;
    endcase
  endfunction

  // normalization over the learned counts
  task automatic normalize_table();
    logic [95:0] ratio;
    logic [95:0] best;
    int          a;
    best = '0;
    foreach (m_pair_count[k]) begin
      a = k >> SYM_BITS;
      ratio = scaled_div(m_pair_count[k], m_row_total[a], RATIO_BITS);
      if (ratio > best) best = ratio;
    end
    m_pair_score.delete();
    if (best != 0) begin
      foreach (m_pair_count[k]) begin
        a = k >> SYM_BITS;
        ratio = scaled_div(m_pair_count[k], m_row_total[a], RATIO_BITS);
        m_pair_score[k] = SCORE_BITS'(scaled_div(ratio[63:0], best[63:0], FRAC_BITS));
      end
    end
    m_trained = 1'b1;
    m_have_prev = 1'b0;
    m_word_sum = '0;
    m_word_pairs = '0;
  endtask

  // advance the model by one accepted item
  task automatic bigram_predict(input in_t it, output bit has, output out_t res);
    int          idx;
    logic [40:0] sum;
    has = 1'b0;
    res = '0;
    idx = {m_prev, it.symbol};
    case (it.command)
      CMD_LEARN: begin
        if (!m_trained) begin
          if (m_have_prev) begin
            if (!m_pair_count.exists(idx)) m_pair_count[idx] = '0;
            if (m_pair_count[idx] != CNT_MAX) m_pair_count[idx]++;
            if (m_row_total[m_prev] != CNT_MAX) m_row_total[m_prev]++;
          end
          m_prev = it.symbol;
          m_have_prev = !it.last;
        end
      end
      CMD_FINALIZE: begin
        normalize_table();
        has = 1'b1;
        res.result_kind = KIND_NORM;
      end
      CMD_SCORE: begin
        if (m_have_prev && m_word_pairs != WCNT_MAX) begin
          sum = m_word_sum + (m_pair_score.exists(idx) ? m_pair_score[idx] : '0);
          m_word_sum = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_BITS-1:0];
          m_word_pairs++;
        end
        m_prev = it.symbol;
        if (it.last) begin
          has = 1'b1;
          res.result_kind = KIND_WORD;
          res.score = (m_word_pairs != 0) ? SCORE_BITS'(m_word_sum / m_word_pairs) : '0;
          m_word_sum = '0;
          m_word_pairs = '0;
          m_have_prev = 1'b0;
        end else begin
          m_have_prev = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // one input transfer with a random gap ahead of it
  task automatic send(input in_t it, input bit known, input out_t known_res);
    int   gap;
    bit   has;
    out_t res;
    gap = 0;
    while ($urandom_range(99) < idle_pct(1'b1) && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    bigram_predict(it, has, res);
    n_items++;
    if (it.command == CMD_FINALIZE) n_finalize++;
    if (has) score_q.push_back(known ? known_res : res);
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] sym, input logic lst);
    in_t it;
    it.command = cmd;
    it.symbol = sym;
    it.last = lst;
    send(it, 1'b0, '0);
  endtask

  function automatic logic [7:0] core_sym();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h41;
      default: return 8'h5A;
    endcase
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct(1'b0));
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (score_q.size() == 0) begin
        $error("unexpected result kind=%0d score=%0d", out_data.result_kind, out_data.score);
        errors++;
      end else begin
        if (out_data.result_kind !== score_q[0].result_kind) begin
          $error("result_kind expected %0d actual %0d",
                 score_q[0].result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.score !== score_q[0].score) begin
          $error("score expected %0d actual %0d", score_q[0].score, out_data.score);
          errors++;
        end
        void'(score_q.pop_front());
      end
    end
  end

  initial begin
    #200_000_000;
    $display("char_bigram_model_train_score_top_test: errors");
    $finish;
  end

  // directed rows: before training, then around finalize
  stim_row_t pre_rows [] = '{
    '{'{CMD_SCORE,    8'h41, 1'b0}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h5A, 1'b1}, 1'b1, '{KIND_WORD, '0}},
    '{'{CMD_SCORE,    8'hFF, 1'b1}, 1'b1, '{KIND_WORD, '0}},
    '{'{CMD_NONE,     8'hFF, 1'b1}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_LEARN,    8'hFF, 1'b0}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h41, 1'b1}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h41, 1'b0}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h5A, 1'b0}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h41, 1'b1}, 1'b1, '{KIND_WORD, '0}},
    '{'{CMD_LEARN,    8'h5A, 1'b0}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h5A, 1'b1}, 1'b0, '0}
  };
  stim_row_t post_rows [] = '{
    '{'{CMD_FINALIZE, 8'hA5, 1'b1}, 1'b1, '{KIND_NORM, '0}},
    '{'{CMD_SCORE,    8'h00, 1'b0}, 1'b0, '0},
    '{'{CMD_SCORE,    8'hFF, 1'b1}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h41, 1'b0}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h41, 1'b0}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h5A, 1'b1}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h41, 1'b0}, 1'b0, '0},
    '{'{CMD_LEARN,    8'h5A, 1'b1}, 1'b0, '0},
    '{'{CMD_SCORE,    8'h5A, 1'b1}, 1'b1, '{KIND_WORD, '0}},
    '{'{CMD_FINALIZE, 8'h00, 1'b0}, 1'b1, '{KIND_NORM, '0}}
  };

  initial begin
    int len;
    int k;
    foreach (m_row_total[i]) m_row_total[i] = '0;
    m_prev = '0;
    m_have_prev = 1'b0;
    m_word_sum = '0;
    m_word_pairs = '0;
    m_trained = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pre_rows[i]) send(pre_rows[i].item, pre_rows[i].known, pre_rows[i].res);

    // random learn lines over a few rows, random tails, some noise
    k = 0;
    while (k < 250) begin
      if ($urandom_range(9) == 0) begin
        send_item($urandom_range(1) ? CMD_NONE : CMD_SCORE, 8'($urandom), 1'($urandom));
        k++;
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len - 1; j++) send_item(CMD_LEARN, core_sym(), 1'b0);
        send_item(CMD_LEARN, $urandom_range(1) ? 8'($urandom) : core_sym(), 1'b1);
        k += len;
      end
    end

    idle_mode = IDLE_SEND_HEAVIER_RECV_HEAVY;
    foreach (post_rows[i]) send(post_rows[i].item, post_rows[i].known, post_rows[i].res);

    // random scored words, with ignored learns and unused commands mixed in
    k = 0;
    while (k < 450) begin
      if (k >= 225) idle_mode = IDLE_NONE;
      if ($urandom_range(9) == 0) begin
        send_item($urandom_range(1) ? CMD_NONE : CMD_LEARN, 8'($urandom), 1'($urandom));
        k++;
      end else begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++)
          send_item(CMD_SCORE, ($urandom_range(9) < 7) ? core_sym() : 8'($urandom),
                    j == len - 1);
        k += len;
      end
    end
    in_valid <= 1'b0;

    while (score_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d input transfers, %0d results, %0d normalization passes",
             n_items, n_results, n_finalize);
    if (errors == 0) begin
      $display("char_bigram_model_train_score_top_test: clean");
    end else begin
      $display("char_bigram_model_train_score_top_test: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_ram.sv
hw/rtl/char_bigram_model_train_score_top.sv
dv/char_bigram_model_train_score_top_test.sv
